// ===== src/ncr_pkg.sv =====
package ncr_pkg;

   localparam int CLUSTER_SLOTS = 16;
   localparam int MAX_DIM       = 64;
   localparam int ELEMENT_BITS  = 16;

   localparam int CLUSTER_BITS  = 4;
   localparam int ELEM_IDX_BITS = 6;
   localparam int DIM_CFG_BITS  = 7;
   localparam int USED_BITS     = 5;
   localparam int TOP_BITS      = 5;
   localparam int DIST_BITS     = 38;
   localparam int SQ_BITS       = 2 * ELEMENT_BITS;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   // sequencer wait counts: first read covers the accumulate pipeline plus one chain pass
   localparam int SWEEP_FIRST = CLUSTER_SLOTS + 3;
   localparam int SWEEP_NEXT  = CLUSTER_SLOTS + 1;
   localparam int WAIT_BITS   = $clog2(SWEEP_FIRST + 1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_DIMENSION     = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLUSTER_COUNT = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP
   } seq_state_type;

   typedef struct packed {
      logic                           wr_en;
      logic                           wr_all;
      logic [CLUSTER_BITS-1:0]        wr_cluster;
      logic [ELEM_IDX_BITS-1:0]       wr_addr;
      logic signed [ELEMENT_BITS-1:0] wr_data;
      logic                           rd_en;
      logic [ELEM_IDX_BITS-1:0]       rd_addr;
      logic signed [ELEMENT_BITS-1:0] q_value;
      logic                           clear_acc;
      logic                           take_en;
      logic [CLUSTER_BITS-1:0]        take_cluster;
      logic [USED_BITS-1:0]           used;
   } cell_ctrl_type;

   typedef struct packed {
      logic                    valid;
      logic [CLUSTER_BITS-1:0] cluster;
      logic [DIST_BITS-1:0]    distance;
   } cand_type;

endpackage

// ===== src/ncr_cell.sv =====
module ncr_cell
   import ncr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CLUSTER_BITS-1:0] cell_id,
   input  cell_ctrl_type           ctrl,
   input  cand_type                cand_in,
   output cand_type                cand_out
);

   logic signed [ELEMENT_BITS-1:0] mem [MAX_DIM];

   logic signed [ELEMENT_BITS-1:0] cent_ff;
   logic signed [ELEMENT_BITS-1:0] q_ff;
   logic                           a_valid_ff;
   logic [SQ_BITS-1:0]             sq_ff;
   logic [SQ_BITS-1:0]             sq_in;
   logic                           b_valid_ff;
   logic [DIST_BITS-1:0]           acc_ff;
   logic [DIST_BITS-1:0]           acc_in;
   logic                           taken_ff;
   cand_type                       cand_ff;
   cand_type                       cand_in_sel;

   logic                           we;
   logic signed [ELEMENT_BITS:0]   diff;
   logic signed [2*ELEMENT_BITS+1:0] prod;
   logic [DIST_BITS:0]             sum;
   logic                           eligible;

   assign we = ctrl.wr_all || (ctrl.wr_en && (ctrl.wr_cluster == cell_id));

   // centroid memory, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         cent_ff <= mem[ctrl.rd_addr];
         q_ff    <= ctrl.q_value;
      end
   end

   assign diff  = {q_ff[ELEMENT_BITS-1], q_ff} - {cent_ff[ELEMENT_BITS-1], cent_ff};
   assign prod  = diff * diff;
   assign sq_in = prod[SQ_BITS-1:0];

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         sq_ff <= sq_in;
      end
   end

   // saturating accumulate
   assign sum = {1'b0, acc_ff} + (DIST_BITS+1)'(sq_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear_acc) begin
         acc_in = '0;
      end else if (b_valid_ff) begin
         if (sum >= {1'b0, DIST_MAX}) begin
            acc_in = DIST_MAX;
         end else begin
            acc_in = sum[DIST_BITS-1:0];
         end
      end
   end

   // running minimum passed down the chain; strict compare keeps the lower index on ties
   assign eligible = !taken_ff && ({1'b0, cell_id} < ctrl.used);

   always_comb begin
      cand_in_sel = cand_in;
      if (eligible && (!cand_in.valid || (acc_ff < cand_in.distance))) begin
         cand_in_sel.valid    = 1'b1;
         cand_in_sel.cluster  = cell_id;
         cand_in_sel.distance = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         acc_ff     <= '0;
         taken_ff   <= 1'b0;
         cand_ff    <= '0;
      end else begin
         a_valid_ff <= ctrl.rd_en;
         b_valid_ff <= a_valid_ff;
         acc_ff     <= acc_in;
         cand_ff    <= cand_in_sel;
         if (ctrl.clear_acc) begin
            taken_ff <= 1'b0;
         end else if (ctrl.take_en && (ctrl.take_cluster == cell_id)) begin
            taken_ff <= 1'b1;
         end
      end
   end

   assign cand_out = cand_ff;

endmodule

// ===== src/ncr_sequencer.sv =====
module ncr_sequencer
   import ncr_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic [DIM_CFG_BITS-1:0]        dim,
   input  logic [USED_BITS-1:0]           used,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [CLUSTER_BITS-1:0]        req_cluster_index,
   input  logic [ELEM_IDX_BITS-1:0]       req_element_index,
   input  logic signed [ELEMENT_BITS-1:0] req_element_value,
   input  logic [TOP_BITS-1:0]            req_top_count,
   input  logic                           req_last_element,
   input  cand_type                       tail,
   output cell_ctrl_type                  ctrl,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [CLUSTER_BITS-1:0]        rsp_ranked_cluster,
   output logic [DIST_BITS-1:0]           rsp_squared_distance,
   output logic                           rsp_last_result
);

   seq_state_type            state_ff, state_in;
   logic [ELEM_IDX_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [WAIT_BITS-1:0]     wait_ff, wait_in;
   logic [TOP_BITS-1:0]      rank_ff, rank_in;
   logic [TOP_BITS-1:0]      count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CLUSTER_BITS-1:0]  rsp_cluster_ff;
   logic [DIST_BITS-1:0]     rsp_dist_ff;
   logic                     rsp_last_ff;

   logic                     accept;
   logic                     load;
   logic                     slot_free;
   logic [TOP_BITS-1:0]      req_count;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_count = (req_top_count < used) ? req_top_count : used;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      wait_in     = wait_ff;
      rank_in     = rank_ff;
      count_in    = count_ff;
      load        = 1'b0;
      req_ready   = 1'b0;

      ctrl              = '0;
      ctrl.used         = used;
      ctrl.wr_cluster   = req_cluster_index;
      ctrl.wr_addr      = req_element_index;
      ctrl.wr_data      = req_element_value;
      ctrl.rd_addr      = req_element_index;
      ctrl.q_value      = req_element_value;
      ctrl.take_cluster = tail.cluster;

      case (state_ff)
         ST_CLEAR: begin
            ctrl.wr_all  = 1'b1;
            ctrl.wr_addr = clr_addr_ff;
            ctrl.wr_data = '0;
            clr_addr_in  = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ELEM_IDX_BITS'(MAX_DIM - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            ctrl.wr_en = accept && (req_operation == OP_WRITE);
            ctrl.rd_en = accept && (req_operation == OP_QUERY)
                         && ({1'b0, req_element_index} < dim);
            if (accept && (req_operation == OP_QUERY) && req_last_element) begin
               state_in = ST_SWEEP;
               wait_in  = WAIT_BITS'(SWEEP_FIRST);
               rank_in  = '0;
               count_in = req_count;
            end
         end
         ST_SWEEP: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else if (rank_ff == count_ff) begin
               ctrl.clear_acc = 1'b1;
               state_in       = ST_IDLE;
            end else if (slot_free) begin
               load         = 1'b1;
               ctrl.take_en = 1'b1;
               rank_in      = rank_ff + 1'b1;
               wait_in      = WAIT_BITS'(SWEEP_NEXT);
               if (rank_in == count_ff) begin
                  ctrl.clear_acc = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wait_ff      <= '0;
         rank_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wait_ff      <= wait_in;
         rank_ff      <= rank_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_cluster_ff <= tail.cluster;
         rsp_dist_ff    <= tail.distance;
         rsp_last_ff    <= (rank_in == count_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ranked_cluster   = rsp_cluster_ff;
   assign rsp_squared_distance = rsp_dist_ff;
   assign rsp_last_result      = rsp_last_ff;

endmodule

// ===== src/nearest_centroid_ranker.sv =====
// Nearest-centroid search with top-N ranking. One cell per cluster holds that
// centroid (a 64-entry element memory) and its squared-distance accumulator.
// Centroid writes and query elements are taken one item per cycle while idle; every query
// element is broadcast to all cells and folds into each accumulator through a
// read / square / saturating-add pipeline. The item marked last starts the
// ranking: a running minimum ripples down the cell chain, one cell per cycle,
// and each result is loaded from the chain tail once the output register is
// free, so an output stall delays it. No item is accepted while ranking; the
// next one is taken in the cycle after the final result is loaded, or after
// the sequencer's wait when no result is asked for.
// Ties go to the lower cluster index. Results wait in an output register.
// After reset a clearing pass zeroes the centroid memories, one row across all
// cells per cycle; configuration writes are taken throughout.
module nearest_centroid_ranker
   import ncr_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]        csr_index,
   input  logic [CSR_DATA_BITS-1:0]       csr_write_data,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [CLUSTER_BITS-1:0]        req_cluster_index,
   input  logic [ELEM_IDX_BITS-1:0]       req_element_index,
   input  logic signed [ELEMENT_BITS-1:0] req_element_value,
   input  logic [TOP_BITS-1:0]            req_top_count,
   input  logic                           req_last_element,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [CLUSTER_BITS-1:0]        rsp_ranked_cluster,
   output logic [DIST_BITS-1:0]           rsp_squared_distance,
   output logic                           rsp_last_result
);

   // configuration registers
   logic [DIM_CFG_BITS-1:0] dimension_ff;
   logic [USED_BITS-1:0]    cluster_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff     <= DIM_CFG_BITS'(MAX_DIM);
         cluster_count_ff <= USED_BITS'(CLUSTER_SLOTS);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DIMENSION:     dimension_ff     <= csr_write_data[DIM_CFG_BITS-1:0];
            REG_CLUSTER_COUNT: cluster_count_ff <= csr_write_data[USED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // out-of-range settings: zero acts as one, too large acts as the maximum
   logic [DIM_CFG_BITS-1:0] dim;
   logic [USED_BITS-1:0]    used;

   always_comb begin
      if (dimension_ff == '0) begin
         dim = DIM_CFG_BITS'(1);
      end else if (dimension_ff > DIM_CFG_BITS'(MAX_DIM)) begin
         dim = DIM_CFG_BITS'(MAX_DIM);
      end else begin
         dim = dimension_ff;
      end
      if (cluster_count_ff == '0) begin
         used = USED_BITS'(1);
      end else if (cluster_count_ff > USED_BITS'(CLUSTER_SLOTS)) begin
         used = USED_BITS'(CLUSTER_SLOTS);
      end else begin
         used = cluster_count_ff;
      end
   end

   cell_ctrl_type ctrl;
   cand_type      chain [CLUSTER_SLOTS+1];

   // head of the chain carries no candidate
   assign chain[0] = '0;

   for (genvar i = 0; i < CLUSTER_SLOTS; i++) begin : g_cell
      ncr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (CLUSTER_BITS'(i)),
         .ctrl     (ctrl),
         .cand_in  (chain[i]),
         .cand_out (chain[i+1])
      );
   end

   ncr_sequencer u_seq (
      .clock                (clock),
      .reset                (reset),
      .dim                  (dim),
      .used                 (used),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_cluster_index    (req_cluster_index),
      .req_element_index    (req_element_index),
      .req_element_value    (req_element_value),
      .req_top_count        (req_top_count),
      .req_last_element     (req_last_element),
      .tail                 (chain[CLUSTER_SLOTS]),
      .ctrl                 (ctrl),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ranked_cluster   (rsp_ranked_cluster),
      .rsp_squared_distance (rsp_squared_distance),
      .rsp_last_result      (rsp_last_result)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import ncr_pkg::*;

   // one input item as the stimulus side sees it; gap is the idle time before it is offered
   typedef struct {
      logic                           op;
      logic [CLUSTER_BITS-1:0]        cluster;
      logic [ELEM_IDX_BITS-1:0]       elem;
      logic signed [ELEMENT_BITS-1:0] value;
      logic [TOP_BITS-1:0]            top;
      logic                           last;
      int                             gap;
   } centroid_req_type;

   // one ranked cluster of a query
   typedef struct {
      logic [CLUSTER_BITS-1:0] cluster;
      logic [DIST_BITS-1:0]    distance;
      logic                    last;
   } ranked_hit_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;

   logic                           csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]        csr_index = '0;
   logic [CSR_DATA_BITS-1:0]       csr_write_data = '0;

   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_operation = OP_WRITE;
   logic [CLUSTER_BITS-1:0]        req_cluster_index = '0;
   logic [ELEM_IDX_BITS-1:0]       req_element_index = '0;
   logic signed [ELEMENT_BITS-1:0] req_element_value = '0;
   logic [TOP_BITS-1:0]            req_top_count = '0;
   logic                           req_last_element = 1'b0;

   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [CLUSTER_BITS-1:0]        rsp_ranked_cluster;
   logic [DIST_BITS-1:0]           rsp_squared_distance;
   logic                           rsp_last_result;

   nearest_centroid_ranker u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_cluster_index    (req_cluster_index),
      .req_element_index    (req_element_index),
      .req_element_value    (req_element_value),
      .req_top_count        (req_top_count),
      .req_last_element     (req_last_element),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ranked_cluster   (rsp_ranked_cluster),
      .rsp_squared_distance (rsp_squared_distance),
      .rsp_last_result      (rsp_last_result)
   );

   // ------------------------------------------------------------------
   // Shadow of the block: centroid table, accumulators, register copies
   // ------------------------------------------------------------------
   logic signed [ELEMENT_BITS-1:0] centroid_mem [CLUSTER_SLOTS][MAX_DIM];
   logic [DIST_BITS-1:0]           dist_acc [CLUSTER_SLOTS];
   logic [CSR_DATA_BITS-1:0]       dim_reg  = 7'd64;
   logic [CSR_DATA_BITS-1:0]       used_reg = 7'd16;

   centroid_req_type req_backlog[$];    // items waiting for the driver
   centroid_req_type req_live;          // item currently offered on the port
   ranked_hit_type   ranked_expect[$];  // predicted results, oldest first

   int  gap_count;
   int  rsp_hold;
   bit  rsp_calm = 1'b0;
   bit  seq_calm = 1'b0;             // no idle gaps for the sequence being built
   int  items_queued = 0;
   int  mismatches = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // out-of-range register values fold into 1..max
   function automatic int dim_in_use();
      int v;
      v = dim_reg;
      if (v < 1) v = 1;
      if (v > MAX_DIM) v = MAX_DIM;
      return v;
   endfunction

   function automatic int used_in_use();
      int v;
      v = used_reg[USED_BITS-1:0];
      if (v < 1) v = 1;
      if (v > CLUSTER_SLOTS) v = CLUSTER_SLOTS;
      return v;
   endfunction

   // Applies one accepted item to the shadow state and queues the ranking it causes.
   task automatic rank_item(input centroid_req_type it);
      int             dim;
      int             used;
      int             count;
      int             best;
      int             diff;
      logic [63:0]    sq;
      logic [63:0]    sum;
      bit             taken [CLUSTER_SLOTS];
      ranked_hit_type hit;
      dim  = dim_in_use();
      used = used_in_use();
      if (it.op == OP_WRITE) begin
         // writes land even past the dimension; last_element means nothing here
         centroid_mem[it.cluster][it.elem] = it.value;
         return;
      end
      // elements past the dimension add nothing but may still close the query
      if (it.elem < dim) begin
         for (int c = 0; c < CLUSTER_SLOTS; c++) begin
            diff = int'(it.value) - int'(centroid_mem[c][it.elem]);
            if (diff < 0) diff = -diff;
            sq  = longint'(diff) * longint'(diff);
            sum = 64'(dist_acc[c]) + sq;
            dist_acc[c] = (sum > 64'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
         end
      end
      if (!it.last) return;
      count = (int'(it.top) < used) ? int'(it.top) : used;
      foreach (taken[c]) taken[c] = 1'b0;
      for (int k = 0; k < count; k++) begin
         best = -1;
         // strict compare keeps the lower index on ties
         for (int c = 0; c < used; c++) begin
            if (!taken[c] && (best < 0 || dist_acc[c] < dist_acc[best])) best = c;
         end
         taken[best] = 1'b1;
         hit.cluster  = CLUSTER_BITS'(best);
         hit.distance = dist_acc[best];
         hit.last     = (k == count - 1);
         ranked_expect = {ranked_expect, hit};
      end
      // cleared after every ranking, top_count 0 included
      foreach (dist_acc[c]) dist_acc[c] = '0;
   endtask

   // ------------------------------------------------------------------
   // Driver: offers backlog items, honoring each item's idle gap
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic             hold_valid;
      centroid_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else begin
         hold_valid = req_valid;
         if (req_valid && req_ready) begin
            rank_item(req_live);
            hold_valid = 1'b0;
         end
         if (!hold_valid && req_backlog.size() != 0) begin
            if (gap_count < req_backlog[0].gap) begin
               gap_count++;
            end else begin
               nxt        = req_backlog.pop_front();
               req_live   = nxt;
               gap_count  = 0;
               hold_valid = 1'b1;
               req_operation     <= nxt.op;
               req_cluster_index <= nxt.cluster;
               req_element_index <= nxt.elem;
               req_element_value <= nxt.value;
               req_top_count     <= nxt.top;
               req_last_element  <= nxt.last;
            end
         end
         // single assignment per edge, so a back-to-back item keeps valid high
         req_valid <= hold_valid;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random back-pressure, compares against the oldest prediction
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      ranked_hit_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ranked_expect.size() == 0) begin
               $display("%0t: unexpected result, expected none actual cluster %0d dist %0d",
                        $time, rsp_ranked_cluster, rsp_squared_distance);
               mismatches++;
            end else begin
               want = ranked_expect.pop_front();
               check_field("ranked_cluster", 64'(want.cluster), 64'(rsp_ranked_cluster));
               check_field("squared_distance", 64'(want.distance),
                           64'(rsp_squared_distance));
               check_field("last_result", 64'(want.last), 64'(rsp_last_result));
            end
            // now and then switch between stalling and streaming stretches
            if ($urandom_range(0, 7) == 0) rsp_calm = !rsp_calm;
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 13);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_item(input logic op, input int cl, input int el, input int val,
                            input int top, input logic last);
      centroid_req_type it;
      it.op      = op;
      it.cluster = CLUSTER_BITS'(cl);
      it.elem    = ELEM_IDX_BITS'(el);
      it.value   = ELEMENT_BITS'(val);
      it.top     = TOP_BITS'(top);
      it.last    = last;
      it.gap     = seq_calm ? 0 : $urandom_range(0, 13);
      req_backlog = {req_backlog, it};
      items_queued++;
   endtask

   // registers only change while the block is idle, so the shadow copy follows at once
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == REG_DIMENSION) dim_reg = data;
      else used_reg = data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // sampled on the falling edge so the driver's updates are settled;
   // the closing wait covers a ranking that asks for no results
   task automatic drain_block();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || ranked_expect.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic int rand_value();
      case ($urandom_range(0, 11))
         0:       return -32768;
         1:       return 32767;
         2:       return -1;
         3:       return 0;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // mostly in range, sometimes zero or past the cluster count
   function automatic int rand_top();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(17, 31);
         2, 3:    return 1;
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   task automatic random_sequence();
      int dim;
      int kind;
      int n;
      int cl;
      int el;
      dim      = dim_in_use();
      seq_calm = ($urandom_range(0, 3) == 0);
      kind     = $urandom_range(0, 99);
      if (kind < 30) begin
         // centroid rows, with a stray element past the dimension now and then
         n = $urandom_range(1, 3);
         repeat (n) begin
            cl = $urandom_range(0, 15);
            for (int e = 0; e < dim; e++) begin
               el = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : e;
               push_item(OP_WRITE, cl, el, rand_value(), $urandom_range(0, 31),
                         1'($urandom_range(0, 1)));
            end
         end
      end else if (kind < 85) begin
         // well-formed query: every element once, in order
         for (int e = 0; e < dim; e++)
            push_item(OP_QUERY, $urandom_range(0, 15), e, rand_value(),
                      (e == dim - 1) ? rand_top() : $urandom_range(0, 31), e == dim - 1);
      end else if (kind < 95) begin
         // broken query: repeats, holes and elements past the dimension
         n = $urandom_range(1, dim + 3);
         for (int i = 0; i < n; i++) begin
            el = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 63)
                                             : $urandom_range(0, dim - 1);
            push_item(OP_QUERY, $urandom_range(0, 15), el, rand_value(), rand_top(),
                      i == n - 1);
         end
      end else begin
         // raw noise on every field
         n = $urandom_range(1, 3);
         repeat (n)
            push_item(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                      $urandom_range(0, 63), $urandom_range(0, 65535),
                      $urandom_range(0, 31), 1'($urandom_range(0, 1)));
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int start;
      int dim_data;
      int cnt_data;
      foreach (centroid_mem[c, e]) centroid_mem[c][e] = '0;
      foreach (dist_acc[c]) dist_acc[c] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset registers (dim 64, 16 clusters in use).
      // Field extremes; last_element on a write is ignored.
      push_item(OP_WRITE, 15, 63, 32767, 31, 1'b1);
      push_item(OP_WRITE, 0, 0, -32768, 0, 1'b0);
      push_item(OP_WRITE, 7, 0, 32767, 0, 1'b0);
      push_item(OP_WRITE, 10, 63, -32768, 16, 1'b0);
      // full ranking; the untouched zero centroids tie and go by index
      push_item(OP_QUERY, 0, 0, 32767, 0, 1'b0);
      push_item(OP_QUERY, 15, 63, -32768, 16, 1'b1);
      // top_count 0: no results, accumulators still cleared
      push_item(OP_QUERY, 0, 0, -32768, 0, 1'b1);
      // repeated element counts twice; top_count above the cluster count is capped
      push_item(OP_QUERY, 0, 0, 1000, 0, 1'b0);
      push_item(OP_QUERY, 0, 0, 1000, 0, 1'b0);
      push_item(OP_QUERY, 0, 5, -1, 31, 1'b1);
      // query of only its last element (all others missing)
      push_item(OP_QUERY, 0, 63, 0, 1, 1'b1);
      push_item(OP_QUERY, 0, 63, -32768, 3, 1'b1);
      drain_block();

      // register values of 0 act as 1: single element, single cluster
      write_reg(REG_DIMENSION, 7'd0);
      write_reg(REG_CLUSTER_COUNT, 7'd0);
      push_item(OP_WRITE, 0, 5, 77, 0, 1'b0);        // stored, past the dimension
      push_item(OP_QUERY, 0, 0, 100, 0, 1'b0);
      push_item(OP_QUERY, 0, 5, -5, 16, 1'b1);       // past the dimension, still ranks
      push_item(OP_QUERY, 0, 2, 9, 1, 1'b1);
      drain_block();

      // Random phases, each with its own register setting
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin dim_data = 127; cnt_data = 31; end  // above max, folds to max
            1: begin dim_data = 1;   cnt_data = 1;  end
            2: begin dim_data = 64;  cnt_data = 16; end
            default: begin
               dim_data = $urandom_range(0, 10);
               cnt_data = $urandom_range(0, 127);         // upper csr bits are dropped
            end
         endcase
         write_reg(REG_DIMENSION, CSR_DATA_BITS'(dim_data));
         write_reg(REG_CLUSTER_COUNT, CSR_DATA_BITS'(cnt_data));
         start = items_queued;
         seq_calm = 1'b0;
         if (p == 0) begin
            // drive one accumulator past 2^38-1 by repeating element 0
            push_item(OP_WRITE, 3, 0, -32768, 0, 1'b0);
            push_item(OP_WRITE, 9, 0, 32767, 0, 1'b0);
            for (int i = 0; i < 66; i++)
               push_item(OP_QUERY, 0, 0, 32767, 16, i == 65);
         end
         if (p == 2) begin
            // one query at the largest dimension
            for (int e = 0; e < 64; e++)
               push_item(OP_QUERY, 0, e, rand_value(), $urandom_range(1, 16), e == 63);
         end
         while (items_queued - start < 15) random_sequence();
         drain_block();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
